// ===== hw/rtl/sumd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package sumd_pkg;

  localparam int MAX_CHANNELS = 16;
  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
  localparam int CQ_DEPTH = 2;
  localparam int CQ_PTR_W = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [15:0] WORD_BIAS = 16'd8800;
  localparam logic [15:0] RECIP_5 = 16'd52429;
  localparam int RECIP_SH = 18;
  localparam logic [15:0] PITCH_OFS = 16'd90;
  localparam logic [15:0] OTHER_OFS = 16'd180;

  localparam logic [1:0] CFG_SYNC_BYTE = 2'd0;
  localparam logic [1:0] CFG_THROTTLE_CHANNEL = 2'd1;
  localparam logic [1:0] CFG_PITCH_CHANNEL = 2'd2;

  localparam logic [7:0] SYNC_RESET = 8'd168;
  localparam logic [3:0] THROTTLE_RESET = 4'd0;
  localparam logic [3:0] PITCH_RESET = 4'd2;

  typedef enum logic [1:0] {
    KIND_THROTTLE,
    KIND_PITCH,
    KIND_OTHER
  } kind_e;

  typedef struct packed {
    logic [7:0] sync_byte;
    logic [3:0] throttle_channel;
    logic [3:0] pitch_channel;
  } cfg_t;

  typedef struct packed {
    logic [3:0]  channel;
    logic [15:0] word;
    kind_e       kind;
    logic        status;
    logic        last;
  } cmd_t;

  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sumd_frame_decoder_top.sv =====
// Path: each result passes parser, queue, scaling unit and output register, in that order.
// Throughput: one byte per cycle while a frame is being received; the scaling unit takes each
// result through LOAD, MUL and OUT (one shared reciprocal multiplier) before it loads the next.
// After the final CRC byte, full stays high while the frame's results enter the 2-entry queue.
// Reset: asynchronous, active low; parser, queue and output register clear, registers
// return to sync 168, throttle channel 0, pitch channel 2. Channel words are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module sumd_frame_decoder_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  rx_byte_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [3:0]       channel_o,
  output logic signed [15:0] value_o,
  output logic             status_o,
  output logic             last_o,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [7:0]  cfg_data_i
);

  sumd_pkg::cfg_t cfg_q;
  sumd_pkg::cmd_t front_cmd, fifo_cmd;
  logic           front_busy;
  logic           cmd_push, cmd_full;
  logic           cmd_pop, cmd_valid;

  assign cfg_ready_o = 1'b1;
  assign full        = front_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_byte        <= sumd_pkg::SYNC_RESET;
      cfg_q.throttle_channel <= sumd_pkg::THROTTLE_RESET;
      cfg_q.pitch_channel    <= sumd_pkg::PITCH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        sumd_pkg::CFG_SYNC_BYTE:        cfg_q.sync_byte        <= cfg_data_i;
        sumd_pkg::CFG_THROTTLE_CHANNEL: cfg_q.throttle_channel <= cfg_data_i[3:0];
        sumd_pkg::CFG_PITCH_CHANNEL:    cfg_q.pitch_channel    <= cfg_data_i[3:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  sumd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (push),
    .rx_byte_i    (rx_byte_i),
    .cfg_i        (cfg_q),
    .busy_o       (front_busy),
    .cmd_o        (front_cmd),
    .cmd_push_o   (cmd_push),
    .cmd_full_i   (cmd_full)
  );

  sumd_cmd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (front_cmd),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .data_o  (fifo_cmd),
    .valid_o (cmd_valid)
  );

  sumd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (fifo_cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .channel_o   (channel_o),
    .value_o     (value_o),
    .status_o    (status_o),
    .last_o      (last_o)
  );

endmodule
`default_nettype wire

// ===== hw/rtl/sumd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sumd_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             byte_valid_i,
  input  wire logic [7:0]       rx_byte_i,
  input  wire sumd_pkg::cfg_t   cfg_i,
  output logic                  busy_o,
  output sumd_pkg::cmd_t        cmd_o,
  output logic                  cmd_push_o,
  input  wire logic             cmd_full_i
);

  logic [9:0]                 idx_q, idx_d;
  logic [7:0]                 nch_q, nch_d;
  logic [15:0]                crc_q, crc_d;
  logic [7:0]                 rcv_hi_q, rcv_hi_d;
  logic                       drain_q, drain_d;
  logic                       bad_q, bad_d;
  logic [sumd_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [sumd_pkg::CNT_W-1:0] ncap_q, ncap_d;
  logic [15:0]                words_q [sumd_pkg::MAX_CHANNELS];

  logic                       accept;
  logic [9:0]                 data_end;
  logic [9:0]                 k;
  logic [8:0]                 wch;
  logic                       store_en;
  logic                       cmd_last;
  logic                       good;

  assign accept   = byte_valid_i & ~drain_q;
  assign data_end = 10'd3 + {1'b0, nch_q, 1'b0};
  assign k        = idx_q - 10'd3;
  assign wch      = k[9:1];
  assign good     = ({rcv_hi_q, rx_byte_i} == crc_q);
  assign busy_o   = drain_q;

  always_comb begin
    idx_d    = idx_q;
    nch_d    = nch_q;
    crc_d    = crc_q;
    rcv_hi_d = rcv_hi_q;
    drain_d  = drain_q;
    bad_d    = bad_q;
    cnt_d    = cnt_q;
    ncap_d   = ncap_q;
    store_en = 1'b0;
    if (accept) begin
      if (idx_q == 10'd0 && rx_byte_i != cfg_i.sync_byte) begin
        idx_d = idx_q;
      end else if (idx_q < 10'd3) begin
        if (idx_q == 10'd2) begin
          nch_d = rx_byte_i;
        end
        crc_d = sumd_pkg::crc_feed(crc_q, rx_byte_i);
        idx_d = idx_q + 10'd1;
      end else if (idx_q < data_end) begin
        crc_d    = sumd_pkg::crc_feed(crc_q, rx_byte_i);
        store_en = (wch < 9'(sumd_pkg::MAX_CHANNELS));
        idx_d    = idx_q + 10'd1;
      end else if (idx_q == data_end) begin
        rcv_hi_d = rx_byte_i;
        idx_d    = idx_q + 10'd1;
      end else begin
        idx_d   = 10'd0;
        crc_d   = 16'd0;
        bad_d   = ~good;
        cnt_d   = '0;
        ncap_d  = (nch_q > 8'(sumd_pkg::MAX_CHANNELS)) ?
                  sumd_pkg::CNT_W'(sumd_pkg::MAX_CHANNELS) : sumd_pkg::CNT_W'(nch_q);
        drain_d = ~good | (nch_q != 8'd0);
      end
    end else if (cmd_push_o) begin
      if (bad_q || cmd_last) begin
        drain_d = 1'b0;
      end else begin
        cnt_d = cnt_q + sumd_pkg::CNT_W'(1);
      end
    end
  end

  assign cmd_last   = (sumd_pkg::CNT_W'(cnt_q + sumd_pkg::CNT_W'(1)) == ncap_q);
  assign cmd_push_o = drain_q & ~cmd_full_i;

  always_comb begin
    if (bad_q) begin
      cmd_o.channel = 4'd0;
      cmd_o.word    = 16'd0;
      cmd_o.kind    = sumd_pkg::KIND_OTHER;
      cmd_o.status  = 1'b1;
      cmd_o.last    = 1'b1;
    end else begin
      cmd_o.channel = 4'(cnt_q);
      cmd_o.word    = words_q[cnt_q[sumd_pkg::CH_W-1:0]];
      if (8'(cnt_q) == 8'(cfg_i.throttle_channel)) begin
        cmd_o.kind = sumd_pkg::KIND_THROTTLE;
      end else if (8'(cnt_q) == 8'(cfg_i.pitch_channel)) begin
        cmd_o.kind = sumd_pkg::KIND_PITCH;
      end else begin
        cmd_o.kind = sumd_pkg::KIND_OTHER;
      end
      cmd_o.status = 1'b0;
      cmd_o.last   = cmd_last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_en) begin
      if (!k[0]) begin
        words_q[wch[sumd_pkg::CH_W-1:0]][15:8] <= rx_byte_i;
      end else begin
        words_q[wch[sumd_pkg::CH_W-1:0]][7:0] <= rx_byte_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      nch_q    <= '0;
      crc_q    <= '0;
      rcv_hi_q <= '0;
      drain_q  <= 1'b0;
      bad_q    <= 1'b0;
      cnt_q    <= '0;
      ncap_q   <= '0;
    end else begin
      idx_q    <= idx_d;
      nch_q    <= nch_d;
      crc_q    <= crc_d;
      rcv_hi_q <= rcv_hi_d;
      drain_q  <= drain_d;
      bad_q    <= bad_d;
      cnt_q    <= cnt_d;
      ncap_q   <= ncap_d;
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sumd_cmd_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sumd_cmd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire sumd_pkg::cmd_t data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output sumd_pkg::cmd_t      data_o,
  output logic                valid_o
);

  sumd_pkg::cmd_t                mem_q [sumd_pkg::CQ_DEPTH];
  logic [sumd_pkg::CQ_PTR_W-1:0] wptr_q, rptr_q;
  logic [sumd_pkg::CQ_CNT_W-1:0] count_q;
  logic                          do_push, do_pop;

  assign full_o  = (count_q == sumd_pkg::CQ_CNT_W'(sumd_pkg::CQ_DEPTH));
  assign valid_o = (count_q != '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & valid_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == sumd_pkg::CQ_PTR_W'(sumd_pkg::CQ_DEPTH - 1)) ?
                  '0 : wptr_q + sumd_pkg::CQ_PTR_W'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == sumd_pkg::CQ_PTR_W'(sumd_pkg::CQ_DEPTH - 1)) ?
                  '0 : rptr_q + sumd_pkg::CQ_PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + sumd_pkg::CQ_CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - sumd_pkg::CQ_CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/sumd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sumd_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire sumd_pkg::cmd_t cmd_i,
  input  wire logic           cmd_valid_i,
  output logic                cmd_pop_o,
  input  wire logic           pop_i,
  output logic                empty_o,
  output logic [3:0]          channel_o,
  output logic signed [15:0]  value_o,
  output logic                status_o,
  output logic                last_o
);

  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_MUL  = 3'b010,
    ST_OUT  = 3'b100
  } st_e;

  st_e                st_q, st_d;
  logic [13:0]        x_q, x_d;
  logic [13:0]        q_q, q_d;
  logic               neg_q, neg_d;
  sumd_pkg::kind_e    kind_q, kind_d;
  logic [3:0]         ch_q, ch_d;
  logic               stat_q, stat_d;
  logic               last_q, last_d;
  logic               out_vld_q, out_vld_d;
  logic [3:0]         out_ch_q, out_ch_d;
  logic [15:0]        out_val_q, out_val_d;
  logic               out_stat_q, out_stat_d;
  logic               out_last_q, out_last_d;

  logic [15:0]        w;
  logic signed [19:0] wx, prod, mag;
  logic [29:0]        m;
  logic [15:0]        smag, offs;
  logic               slot_free;

  assign w    = cmd_i.word - sumd_pkg::WORD_BIAS;
  assign wx   = {{4{w[15]}}, w};
  assign prod = (cmd_i.kind == sumd_pkg::KIND_THROTTLE) ? wx : wx + (wx <<< 3);
  assign mag  = prod[19] ? -prod : prod;
  assign m    = 30'(x_q) * 30'(sumd_pkg::RECIP_5);
  assign smag = neg_q ? -16'(q_q) : 16'(q_q);

  always_comb begin
    case (kind_q)
      sumd_pkg::KIND_PITCH: offs = sumd_pkg::PITCH_OFS;
      sumd_pkg::KIND_OTHER: offs = sumd_pkg::OTHER_OFS;
      default:              offs = 16'd0;
    endcase
  end

  assign slot_free = ~out_vld_q | pop_i;
  assign cmd_pop_o = (st_q == ST_LOAD) & cmd_valid_i;

  always_comb begin
    st_d       = st_q;
    x_d        = x_q;
    q_d        = q_q;
    neg_d      = neg_q;
    kind_d     = kind_q;
    ch_d       = ch_q;
    stat_d     = stat_q;
    last_d     = last_q;
    out_vld_d  = out_vld_q & ~pop_i;
    out_ch_d   = out_ch_q;
    out_val_d  = out_val_q;
    out_stat_d = out_stat_q;
    out_last_d = out_last_q;
    case (st_q)
      ST_LOAD: begin
        if (cmd_valid_i) begin
          neg_d  = prod[19];
          x_d    = (cmd_i.kind == sumd_pkg::KIND_OTHER) ? 14'(mag >>> 5) : 14'(mag >>> 6);
          kind_d = cmd_i.kind;
          ch_d   = cmd_i.channel;
          stat_d = cmd_i.status;
          last_d = cmd_i.last;
          st_d   = ST_MUL;
        end
      end
      ST_MUL: begin
        q_d  = (kind_q == sumd_pkg::KIND_THROTTLE) ? x_q : 14'(m >> sumd_pkg::RECIP_SH);
        st_d = ST_OUT;
      end
      ST_OUT: begin
        if (slot_free) begin
          out_vld_d  = 1'b1;
          out_ch_d   = stat_q ? 4'd0 : ch_q;
          out_val_d  = stat_q ? 16'd0 : smag - offs;
          out_stat_d = stat_q;
          out_last_d = last_q;
          st_d       = ST_LOAD;
        end
      end
      default: begin
        st_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    q_q        <= q_d;
    neg_q      <= neg_d;
    kind_q     <= kind_d;
    ch_q       <= ch_d;
    stat_q     <= stat_d;
    last_q     <= last_d;
    out_ch_q   <= out_ch_d;
    out_val_q  <= out_val_d;
    out_stat_q <= out_stat_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q      <= ST_LOAD;
      out_vld_q <= 1'b0;
    end else begin
      st_q      <= st_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign empty_o   = ~out_vld_q;
  assign channel_o = out_ch_q;
  assign value_o   = out_val_q;
  assign status_o  = out_stat_q;
  assign last_o    = out_last_q;

endmodule
`default_nettype wire

// ===== hw/rtl/sumd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module sumd_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        empty,
  input  wire logic        pop,
  input  wire logic [3:0]  channel_o,
  input  wire logic [15:0] value_o,
  input  wire logic        status_o,
  input  wire logic        last_o
);

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty)
    else $error("result dropped without pop");

  a_payload_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> $stable(value_o) && $stable(channel_o) && $stable(last_o))
    else $error("result changed while waiting");

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && status_o |-> last_o)
    else $error("error result not marked last");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && status_o |-> value_o == 16'd0 && channel_o == 4'd0)
    else $error("error result carries data");

endmodule

bind sumd_frame_decoder_top sumd_checker u_checker (.*);
`default_nettype wire
